// File: src/ars_pkg.sv
// ----------------------------------------------------------------------------
// ars_pkg
// Shared types and constants for the retransmitting sender.
// ----------------------------------------------------------------------------
package ars_pkg;

   localparam int unsigned OP_W    = 3;
   localparam int unsigned CH_W    = 2;
   localparam int unsigned ST_W    = 3;
   localparam int unsigned CNT_W   = 8;
   localparam int unsigned MASK_W  = 4;
   localparam int unsigned ADDR_W  = 4;
   localparam int unsigned DATA_W  = 32;

   localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
   localparam logic [OP_W-1:0] OP_ACK    = 3'd1;
   localparam logic [OP_W-1:0] OP_NACK   = 3'd2;
   localparam logic [OP_W-1:0] OP_TOGGLE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
   localparam logic [OP_W-1:0] OP_START  = 3'd5;

   localparam logic [ST_W-1:0] ST_INIT  = 3'd0;
   localparam logic [ST_W-1:0] ST_READY = 3'd1;
   localparam logic [ST_W-1:0] ST_TX    = 3'd2;
   localparam logic [ST_W-1:0] ST_WAIT  = 3'd3;
   localparam logic [ST_W-1:0] ST_END   = 3'd4;

   localparam logic [1:0] REG_TIMEOUT   = 2'd0;
   localparam logic [1:0] REG_RETRY     = 2'd1;
   localparam logic [1:0] REG_CYCLIC    = 2'd2;
   localparam logic [1:0] REG_ACK_CHECK = 2'd3;

   localparam logic [CNT_W-1:0]  TIMEOUT_RST   = 8'd10;
   localparam logic [CNT_W-1:0]  RETRY_RST     = 8'd3;
   localparam logic [MASK_W-1:0] CYCLIC_RST    = 4'hf;
   localparam logic [MASK_W-1:0] ACK_CHECK_RST = 4'h0;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]  timeout_reload;
      logic [CNT_W-1:0]  retry_limit;
      logic [MASK_W-1:0] cyclic_mask;
      logic [MASK_W-1:0] ack_check_mask;
   } cfg_type;

endpackage

// File: src/ack_retransmit_sender.sv
// ----------------------------------------------------------------------------
// ack_retransmit_sender
// Stop-and-wait sender for a table of message channels, with CSR block.
// ----------------------------------------------------------------------------
// The controller captures a request word, then commits it to the channel table
// and the result register; no new word is taken until the commit is done.
// A stalled result holds the commit until the result register is taken.
// Reset (synchronous): channels to init, counters and CSRs to defaults,
// flags cleared, no result pending.
module ack_retransmit_sender #(
   parameter int unsigned CHANNELS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ars_pkg::OP_W-1:0]      req_op,
   input  logic [ars_pkg::CH_W-1:0]      req_channel,
   input  logic                          req_bus_accept,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ars_pkg::CH_W-1:0]      rsp_out_channel,
   output logic                          rsp_tx_attempt,
   output logic [ars_pkg::ST_W-1:0]      rsp_state_code,
   output logic                          rsp_active,
   output logic                          rsp_gave_up,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ars_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [ars_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [ars_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import ars_pkg::*;

   cmd_type cmd;
   cfg_type cfg_ff, cfg_in;
   logic    csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_TIMEOUT:   cfg_in.timeout_reload = csr_pwdata[CNT_W-1:0];
            REG_RETRY:     cfg_in.retry_limit    = csr_pwdata[CNT_W-1:0];
            REG_CYCLIC:    cfg_in.cyclic_mask    = csr_pwdata[MASK_W-1:0];
            REG_ACK_CHECK: cfg_in.ack_check_mask = csr_pwdata[MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_TIMEOUT:   csr_prdata = DATA_W'(cfg_ff.timeout_reload);
         REG_RETRY:     csr_prdata = DATA_W'(cfg_ff.retry_limit);
         REG_CYCLIC:    csr_prdata = DATA_W'(cfg_ff.cyclic_mask);
         REG_ACK_CHECK: csr_prdata = DATA_W'(cfg_ff.ack_check_mask);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_reload <= TIMEOUT_RST;
         cfg_ff.retry_limit    <= RETRY_RST;
         cfg_ff.cyclic_mask    <= CYCLIC_RST;
         cfg_ff.ack_check_mask <= ACK_CHECK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ars_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ars_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg_ff),
      .req_op          (req_op),
      .req_channel     (req_channel),
      .req_bus_accept  (req_bus_accept),
      .rsp_out_channel (rsp_out_channel),
      .rsp_tx_attempt  (rsp_tx_attempt),
      .rsp_state_code  (rsp_state_code),
      .rsp_active      (rsp_active),
      .rsp_gave_up     (rsp_gave_up)
   );

endmodule

// File: src/ars_ctrl.sv
// ----------------------------------------------------------------------------
// ars_ctrl
// Handshake controller: captures a request word, then commits it to the
// channel table once the result register is free.
// ----------------------------------------------------------------------------
module ars_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ars_pkg::cmd_type cmd
);
   import ars_pkg::*;

   typedef enum logic [1:0] {
      CT_IDLE = 2'b01,
      CT_EXEC = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         CT_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = CT_EXEC;
            end
         end
         CT_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = CT_IDLE;
            end
         end
         default: begin
            state_in = CT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CT_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/ars_datapath.sv
// ----------------------------------------------------------------------------
// ars_datapath
// Channel table (state, counters, flags), next-state logic and the result
// register.
// ----------------------------------------------------------------------------
module ars_datapath #(
   parameter int unsigned CHANNELS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ars_pkg::cmd_type            cmd,
   input  ars_pkg::cfg_type            cfg,
   input  logic [ars_pkg::OP_W-1:0]    req_op,
   input  logic [ars_pkg::CH_W-1:0]    req_channel,
   input  logic                        req_bus_accept,
   output logic [ars_pkg::CH_W-1:0]    rsp_out_channel,
   output logic                        rsp_tx_attempt,
   output logic [ars_pkg::ST_W-1:0]    rsp_state_code,
   output logic                        rsp_active,
   output logic                        rsp_gave_up
);
   import ars_pkg::*;

   localparam int unsigned CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // captured request word
   logic [OP_W-1:0] op_ff;
   logic [CH_W-1:0] ch_ff;
   logic            accept_ff;

   // channel table
   logic [ST_W-1:0]  cs_ff [CHANNELS];
   logic [ST_W-1:0]  cs_in [CHANNELS];
   logic [CNT_W-1:0] wc_ff [CHANNELS];
   logic [CNT_W-1:0] wc_in [CHANNELS];
   logic [CNT_W-1:0] rl_ff [CHANNELS];
   logic [CNT_W-1:0] rl_in [CHANNELS];
   logic [CHANNELS-1:0] act_ff, act_in;
   logic [CHANNELS-1:0] ack_ff, ack_in;

   // result register
   logic [CH_W-1:0] ochan_ff, ochan_in;
   logic            tx_ff, tx_in;
   logic [ST_W-1:0] code_ff, code_in;
   logic            oact_ff, oact_in;
   logic            gave_ff, gave_in;

   logic [CIDX_W+CH_W-1:0] ch_ext;
   logic [CIDX_W-1:0]      ch_idx;
   logic                   ch_ok;
   logic [CHANNELS-1:0]    cyc_vec;

   logic [ST_W-1:0]  cs_rd, ns;
   logic [CNT_W-1:0] wc_rd, nw;
   logic [CNT_W-1:0] rl_rd, nr;
   logic             act_rd, na;
   logic             ack_rd, nk;
   logic             tx, gave;
   logic             cyc_bit, chk_bit;

   assign ch_ext = {{CIDX_W{1'b0}}, ch_ff};
   assign ch_idx = ch_ext[CIDX_W-1:0];
   assign ch_ok  = 32'(ch_ff) < CHANNELS;

   for (genvar g = 0; g < CHANNELS; g++) begin : g_cyc
      if (g < MASK_W) begin : g_in
         assign cyc_vec[g] = cfg.cyclic_mask[g];
      end else begin : g_out
         assign cyc_vec[g] = 1'b0;
      end
   end

   assign cs_rd   = cs_ff[ch_idx];
   assign wc_rd   = wc_ff[ch_idx];
   assign rl_rd   = rl_ff[ch_idx];
   assign act_rd  = act_ff[ch_idx];
   assign ack_rd  = ack_ff[ch_idx];
   assign cyc_bit = cfg.cyclic_mask[ch_ff];
   assign chk_bit = cfg.ack_check_mask[ch_ff];

   // single-channel step
   always_comb begin
      ns   = cs_rd;
      nw   = wc_rd;
      nr   = rl_rd;
      na   = act_rd;
      nk   = ack_rd;
      tx   = 1'b0;
      gave = 1'b0;
      case (op_ff)
         OP_TICK: begin
            case (cs_rd)
               ST_INIT: begin
                  nw = cfg.timeout_reload;
                  if (act_rd) begin
                     ns = ST_READY;
                  end
               end
               ST_READY: begin
                  nr = cfg.retry_limit;
                  ns = ST_TX;
               end
               ST_TX: begin
                  nw = cfg.timeout_reload;
                  nk = 1'b0;
                  tx = 1'b1;
                  ns = accept_ff ? ST_WAIT : ST_TX;
               end
               ST_WAIT: begin
                  if (!chk_bit) begin
                     ns = ST_TX;
                  end else if (wc_rd != '0) begin
                     if (ack_rd) begin
                        if (cyc_bit) begin
                           ns = ST_TX;
                        end else begin
                           ns = ST_INIT;
                           na = 1'b0;
                        end
                     end
                     nw = wc_rd - 1'b1;
                  end else if (rl_rd != '0) begin
                     ns = ST_READY;
                     nr = rl_rd - 1'b1;
                  end else begin
                     ns   = ST_END;
                     gave = 1'b1;
                  end
               end
               default: begin
                  ns = ST_INIT;
               end
            endcase
         end
         OP_ACK: begin
            nk = 1'b1;
         end
         OP_NACK: begin
            nk = 1'b0;
            nw = '0;
         end
         OP_TOGGLE: begin
            na = ~act_rd;
         end
         default: begin
         end
      endcase
   end

   // table update and result
   always_comb begin
      cs_in    = cs_ff;
      wc_in    = wc_ff;
      rl_in    = rl_ff;
      act_in   = act_ff;
      ack_in   = ack_ff;
      ochan_in = ch_ff;
      tx_in    = 1'b0;
      code_in  = '0;
      oact_in  = 1'b0;
      gave_in  = 1'b0;
      if (op_ff == OP_CLEAR || op_ff == OP_START) begin
         if (op_ff == OP_CLEAR) begin
            ack_in = '0;
         end else begin
            act_in = cyc_vec;
         end
         ochan_in = '0;
         code_in  = cs_ff[0];
         oact_in  = act_in[0];
      end else if (ch_ok) begin
         cs_in[ch_idx]  = ns;
         wc_in[ch_idx]  = nw;
         rl_in[ch_idx]  = nr;
         act_in[ch_idx] = na;
         ack_in[ch_idx] = nk;
         tx_in          = tx;
         code_in        = ns;
         oact_in        = na;
         gave_in        = gave;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_op;
         ch_ff     <= req_channel;
         accept_ff <= req_bus_accept;
      end
      if (cmd.execute) begin
         ochan_ff <= ochan_in;
         tx_ff    <= tx_in;
         code_ff  <= code_in;
         oact_ff  <= oact_in;
         gave_ff  <= gave_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            cs_ff[i] <= ST_INIT;
            wc_ff[i] <= TIMEOUT_RST;
            rl_ff[i] <= RETRY_RST;
         end
         act_ff <= '0;
         ack_ff <= '0;
      end else if (cmd.execute) begin
         cs_ff  <= cs_in;
         wc_ff  <= wc_in;
         rl_ff  <= rl_in;
         act_ff <= act_in;
         ack_ff <= ack_in;
      end
   end

   assign rsp_out_channel = ochan_ff;
   assign rsp_tx_attempt  = tx_ff;
   assign rsp_state_code  = code_ff;
   assign rsp_active      = oact_ff;
   assign rsp_gave_up     = gave_ff;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stop-and-wait retransmitting sender.
// A directed table steps the channel machine through transmit, bus refusal,
// nack-forced retry, retry exhaustion and acknowledged return, then random
// words run under six CSR settings with varying back-pressure on both sides.
// Each result word is compared with a behavioural model of the channel table, or with the word given in a directed row.
// ----------------------------------------------------------------------------
module tb_top;
   import ars_pkg::*;

   localparam int NUM_CH = 4;
   localparam int RAND_PER_PHASE = 130;
   localparam int NUM_PHASES = 6;
   localparam int LONG_HOLD = 200;
   localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

   typedef struct packed {
      logic [CH_W-1:0] out_channel;
      logic            tx_attempt;
      logic [ST_W-1:0] state_code;
      logic            active;
      logic            gave_up;
   } sender_result_type;

   typedef enum logic [2:0] {
      ROW_WORD, ROW_TIMEOUT, ROW_RETRY, ROW_CYCLIC, ROW_ACK_CHECK
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [OP_W-1:0]   op;
      logic [CH_W-1:0]   ch;
      logic              accept;
      logic              typed;
      sender_result_type want;
      logic [7:0]        cfg_val;
   } dir_row_type;

   localparam sender_result_type NO_TYPED = '0;
   localparam int DIR_ROWS = 30;

   localparam dir_row_type DIRECTED_TABLE [DIR_ROWS] = '{
      // defaults: ack not checked, every channel cyclic
      '{ROW_WORD, OP_TICK, 2'd0, 1'b0, 1'b1, '{2'd0, 1'b0, ST_INIT, 1'b0, 1'b0}, 8'd0},
      '{ROW_WORD, OP_TOGGLE, 2'd0, 1'b0, 1'b1, '{2'd0, 1'b0, ST_INIT, 1'b1, 1'b0}, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd0, 1'b1, 1'b1, '{2'd0, 1'b0, ST_READY, 1'b1, 1'b0}, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd0, 1'b0, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd0, 1'b0, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd0, 1'b1, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd0, 1'b0, 1'b0, NO_TYPED, 8'd0},
      // spare op codes leave the table alone
      '{ROW_WORD, OP_UNUSED_A, 2'd1, 1'b1, 1'b1, '{2'd1, 1'b0, ST_INIT, 1'b0, 1'b0}, 8'd0},
      '{ROW_WORD, OP_UNUSED_B, 2'd3, 1'b1, 1'b1, '{2'd3, 1'b0, ST_INIT, 1'b0, 1'b0}, 8'd0},
      '{ROW_WORD, OP_START, 2'd3, 1'b0, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_CLEAR, 2'd2, 1'b1, 1'b0, NO_TYPED, 8'd0},
      '{ROW_TIMEOUT, OP_TICK, 2'd0, 1'b0, 1'b0, NO_TYPED, 8'd1},
      '{ROW_RETRY, OP_TICK, 2'd0, 1'b0, 1'b0, NO_TYPED, 8'd0},
      '{ROW_CYCLIC, OP_TICK, 2'd0, 1'b0, 1'b0, NO_TYPED, 8'hb},
      '{ROW_ACK_CHECK, OP_TICK, 2'd0, 1'b0, 1'b0, NO_TYPED, 8'hf},
      // channel 2 single shot, runs out of retries
      '{ROW_WORD, OP_START, 2'd0, 1'b0, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_TOGGLE, 2'd2, 1'b0, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd2, 1'b0, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd2, 1'b0, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd2, 1'b1, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd2, 1'b0, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd2, 1'b0, 1'b1, '{2'd2, 1'b0, ST_END, 1'b1, 1'b1}, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd2, 1'b0, 1'b0, NO_TYPED, 8'd0},
      // channel 0: nack forces a retry, then an ack returns it to transmit
      '{ROW_WORD, OP_TICK, 2'd0, 1'b1, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_NACK, 2'd0, 1'b0, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd0, 1'b0, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd0, 1'b0, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd0, 1'b1, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_ACK, 2'd0, 1'b0, 1'b0, NO_TYPED, 8'd0},
      '{ROW_WORD, OP_TICK, 2'd0, 1'b0, 1'b0, NO_TYPED, 8'd0}
   };

   localparam cfg_type PHASE_CFG [NUM_PHASES] = '{
      '{8'd3,   8'd2,   4'h5, 4'hf},
      '{8'd0,   8'd0,   4'h0, 4'hf},
      '{8'd255, 8'd255, 4'hf, 4'hf},
      '{8'd1,   8'd1,   4'ha, 4'h6},
      '{8'd6,   8'd4,   4'h3, 4'h0},
      '{8'd2,   8'd1,   4'hc, 4'h9}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_op;
   logic [CH_W-1:0]     req_channel;
   logic                req_bus_accept;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [CH_W-1:0]     rsp_out_channel;
   logic                rsp_tx_attempt;
   logic [ST_W-1:0]     rsp_state_code;
   logic                rsp_active;
   logic                rsp_gave_up;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [DATA_W-1:0]   csr_pwdata;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   // channel table model
   cfg_type             model_cfg;
   logic [ST_W-1:0]     chan_st [NUM_CH];
   logic [CNT_W-1:0]    wait_left [NUM_CH];
   logic [CNT_W-1:0]    retries [NUM_CH];
   logic [NUM_CH-1:0]   active_bits;
   logic [NUM_CH-1:0]   acked_bits;

   sender_result_type   expected_results [$];
   sender_result_type   seen_word;
   sender_result_type   due_word;
   int                  mismatch_count = 0;
   int                  tx_gap_pct = 0;
   int                  rx_stall_pct = 0;
   bit                  hold_armed = 1'b0;
   bit                  hold_taken = 1'b0;
   int                  hold_left = 0;

   ack_retransmit_sender #(.CHANNELS(NUM_CH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_channel     (req_channel),
      .req_bus_accept  (req_bus_accept),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_tx_attempt  (rsp_tx_attempt),
      .rsp_state_code  (rsp_state_code),
      .rsp_active      (rsp_active),
      .rsp_gave_up     (rsp_gave_up),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("ack_retransmit_sender verification failed");
      $finish;
   end

   function automatic sender_result_type advance_channel_table(
         input logic [OP_W-1:0] op,
         input logic [CH_W-1:0] ch,
         input logic accept);
      sender_result_type r;
      logic [CH_W-1:0] rep;
      int i;
      r = '0;
      rep = ch;
      case (op)
         OP_CLEAR: begin
            acked_bits = '0;
            rep = '0;
         end
         OP_START: begin
            for (i = 0; i < NUM_CH; i++) active_bits[i] = model_cfg.cyclic_mask[i];
            rep = '0;
         end
         OP_ACK: acked_bits[ch] = 1'b1;
         OP_NACK: begin
            acked_bits[ch] = 1'b0;
            wait_left[ch] = '0;
         end
         OP_TOGGLE: active_bits[ch] = ~active_bits[ch];
         OP_TICK: begin
            case (chan_st[ch])
               ST_INIT: begin
                  wait_left[ch] = model_cfg.timeout_reload;
                  if (active_bits[ch]) chan_st[ch] = ST_READY;
               end
               ST_READY: begin
                  retries[ch] = model_cfg.retry_limit;
                  chan_st[ch] = ST_TX;
               end
               ST_TX: begin
                  wait_left[ch] = model_cfg.timeout_reload;
                  acked_bits[ch] = 1'b0;
                  r.tx_attempt = 1'b1;
                  chan_st[ch] = accept ? ST_WAIT : ST_TX;
               end
               ST_WAIT: begin
                  if (!model_cfg.ack_check_mask[ch]) begin
                     chan_st[ch] = ST_TX;
                  end else if (wait_left[ch] != 0) begin
                     if (acked_bits[ch]) begin
                        if (model_cfg.cyclic_mask[ch]) begin
                           chan_st[ch] = ST_TX;
                        end else begin
                           chan_st[ch] = ST_INIT;
                           active_bits[ch] = 1'b0;
                        end
                     end
                     wait_left[ch] = wait_left[ch] - 1'b1;
                  end else if (retries[ch] != 0) begin
                     chan_st[ch] = ST_READY;
                     retries[ch] = retries[ch] - 1'b1;
                  end else begin
                     chan_st[ch] = ST_END;
                     r.gave_up = 1'b1;
                  end
               end
               default: chan_st[ch] = ST_INIT;
            endcase
         end
         default: ;
      endcase
      r.out_channel = rep;
      r.state_code = chan_st[rep];
      r.active = active_bits[rep];
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                            input logic accept, input logic typed,
                            input sender_result_type want);
      sender_result_type predicted;
      while ($urandom_range(99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_channel <= ch;
      req_bus_accept <= accept;
      do @(posedge clock); while (!req_ready);
      predicted = advance_channel_table(op, ch, accept);
      expected_results.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_results.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      logic [DATA_W-1:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= DATA_W'(val);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      if (readback !== DATA_W'(val)) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("csr readback at %0d: expected %0h, got %0h", idx, val, readback);
      end
      case (idx)
         REG_TIMEOUT:   model_cfg.timeout_reload = val;
         REG_RETRY:     model_cfg.retry_limit = val;
         REG_CYCLIC:    model_cfg.cyclic_mask = val[MASK_W-1:0];
         REG_ACK_CHECK: model_cfg.ack_check_mask = val[MASK_W-1:0];
         default: ;
      endcase
   endtask

   // result side: random stalls plus one long hold-off when armed
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_word = '{rsp_out_channel, rsp_tx_attempt, rsp_state_code, rsp_active,
                       rsp_gave_up};
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word: ch=%0d tx=%0d st=%0d act=%0d gu=%0d",
                        seen_word.out_channel, seen_word.tx_attempt, seen_word.state_code,
                        seen_word.active, seen_word.gave_up);
         end else begin
            due_word = expected_results.pop_front();
            if (seen_word !== due_word) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result mismatch: exp ch=%0d tx=%0d st=%0d act=%0d gu=%0d",
                           due_word.out_channel, due_word.tx_attempt,
                           due_word.state_code, due_word.active, due_word.gave_up);
                  $display("                 got ch=%0d tx=%0d st=%0d act=%0d gu=%0d",
                           seen_word.out_channel, seen_word.tx_attempt,
                           seen_word.state_code, seen_word.active, seen_word.gave_up);
               end
            end
         end
      end
   end

   initial begin
      dir_row_type row;
      cfg_type pc;
      logic [OP_W-1:0] op;
      logic [CH_W-1:0] ch;
      logic acc;
      int unsigned pick;
      int i;
      int n;
      int phase;

      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_TICK;
      req_channel = '0;
      req_bus_accept = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;

      model_cfg = '{TIMEOUT_RST, RETRY_RST, CYCLIC_RST, ACK_CHECK_RST};
      for (i = 0; i < NUM_CH; i++) begin
         chan_st[i] = ST_INIT;
         wait_left[i] = TIMEOUT_RST;
         retries[i] = RETRY_RST;
      end
      active_bits = '0;
      acked_bits = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      tx_gap_pct = 8;
      rx_stall_pct = 61;
      for (i = 0; i < DIR_ROWS; i++) begin
         row = DIRECTED_TABLE[i];
         if (row.kind == ROW_WORD) begin
            send_word(row.op, row.ch, row.accept, row.typed, row.want);
         end else begin
            wait_drained();
            case (row.kind)
               ROW_TIMEOUT:   write_csr(REG_TIMEOUT, row.cfg_val);
               ROW_RETRY:     write_csr(REG_RETRY, row.cfg_val);
               ROW_CYCLIC:    write_csr(REG_CYCLIC, row.cfg_val);
               ROW_ACK_CHECK: write_csr(REG_ACK_CHECK, row.cfg_val);
               default: ;
            endcase
         end
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         pc = PHASE_CFG[phase];
         write_csr(REG_TIMEOUT, pc.timeout_reload);
         write_csr(REG_RETRY, pc.retry_limit);
         write_csr(REG_CYCLIC, 8'(pc.cyclic_mask));
         write_csr(REG_ACK_CHECK, 8'(pc.ack_check_mask));
         case (phase / 2)
            0: begin
               tx_gap_pct = 8;
               rx_stall_pct = 61;
            end
            1: begin
               tx_gap_pct = 61;
               rx_stall_pct = 8;
            end
            default: begin
               tx_gap_pct = 0;
               rx_stall_pct = 0;
            end
         endcase
         for (n = 0; n < RAND_PER_PHASE; n++) begin
            if (phase == NUM_PHASES - 1 && n == 40) hold_armed = 1'b1;
            ch = CH_W'($urandom_range(NUM_CH - 1));
            pick = $urandom_range(99);
            acc = ($urandom_range(99) < 70);
            // favour acks on channels sitting in the wait state
            if (chan_st[ch] == ST_WAIT && model_cfg.ack_check_mask[ch] && pick < 25)
               op = OP_ACK;
            else if (pick < 58)
               op = OP_TICK;
            else if (pick < 66)
               op = OP_ACK;
            else if (pick < 71)
               op = OP_NACK;
            else if (pick < 80)
               op = OP_TOGGLE;
            else if (pick < 84)
               op = OP_CLEAR;
            else if (pick < 92)
               op = OP_START;
            else
               op = $urandom_range(1) ? OP_UNUSED_A : OP_UNUSED_B;
            send_word(op, ch, acc, 1'b0, NO_TYPED);
         end
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (expected_results.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("ack_retransmit_sender verification clean");
      end else begin
         $display("ack_retransmit_sender verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
src/ars_pkg.sv
src/ars_ctrl.sv
src/ars_datapath.sv
src/ack_retransmit_sender.sv
tb/tb_top.sv
